@@ rtl/mme_pkg.sv @@
// Shared types and constants for the matrix multiply engine.
// Depends on nothing; every other file of the block but mme_ram imports it.
package mme_pkg;

    localparam int MAX_DIM_DEF = 8;
    localparam int KIND_W      = 2;
    localparam int IDX_W       = 3;
    localparam int DIM_W       = 4;
    localparam int ELEM_W      = 16;
    localparam int PROD_W      = 32;
    localparam int DOT_W       = 35;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD_A = 2'd0,
        KIND_LOAD_B = 2'd1,
        KIND_START  = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_A    = 2'd0,
        CFG_INNER_DIM = 2'd1,
        CFG_COLS_B    = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_term;
        logic             last_elem;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } tag_t;

endpackage

@@ rtl/mme_cmd_if.sv @@
// Command channel of the matrix multiply engine: element loads and start items.
// Depends on mme_pkg for the field widths.
interface mme_cmd_if
    import mme_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [ELEM_W-1:0] elem_value;

    modport source (output valid, kind, row_index, col_index, elem_value, input ready);
    modport sink   (input valid, kind, row_index, col_index, elem_value, output ready);
endinterface

@@ rtl/mme_res_if.sv @@
// Result channel of the matrix multiply engine: one item per element of C.
// Depends on mme_pkg for the field widths.
interface mme_res_if
    import mme_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [DOT_W-1:0] dot_value;
    logic                    last;

    modport source (output valid, out_row, out_col, dot_value, last, input ready);
    modport sink   (input valid, out_row, out_col, dot_value, last, output ready);
endinterface

@@ rtl/mme_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/matrix_multiply_engine.sv @@
// Top level of the matrix multiply engine: element stores, sequencer and MAC pipeline.
// Depends on mme_pkg, mme_cmd_if, mme_res_if and mme_ram.

// The engine keeps A and B in two RAMs of MAX_DIM*MAX_DIM elements, row-major. A load
// item writes one element and the engine takes the next item straight away.
// A start item multiplies the active shapes: the sequencer reads one element of A and one
// of B per cycle unless the result channel stalls, so each element of C sums inner_dim
// products; no command is taken during a run or the pipeline drain that follows it, and
// the next command is taken in the cycle after the final result item has left. Results
// leave through an output register; a stalled result channel freezes the pipeline
// and adds its stall cycles to the run. Dimension registers of zero act as one and
// values above MAX_DIM act as MAX_DIM; they must only be written while the engine is
// idle.
module matrix_multiply_engine
    import mme_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    mme_cmd_if.sink              cmd,
    mme_res_if.source            res,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);

    logic [DIM_W-1:0] rows_a_reg, inner_dim_reg, cols_b_reg;
    logic [IDX_W-1:0] m_last_reg, k_last_reg, n_last_reg;
    logic [IDX_W-1:0] m_last_next, k_last_next, n_last_next;
    logic [IDX_W-1:0] i_reg, j_reg, l_reg, i_next, j_next, l_next;
    state_t           state_reg, state_next;

    logic             cmd_fire, stall, issue;
    logic             a_we, b_we;
    logic [AW-1:0]    waddr, a_raddr, b_raddr;
    logic [ELEM_W-1:0] a_rdata, b_rdata;

    tag_t                     s1_reg, s1_next, s2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [DOT_W-1:0]  acc_reg, acc_next;

    logic                     res_valid_reg;
    logic [IDX_W-1:0]         res_row_reg, res_col_reg;
    logic signed [DOT_W-1:0]  res_dot_reg;
    logic                     res_last_reg;

    function automatic logic [IDX_W-1:0] last_index(input logic [DIM_W-1:0] d);
        logic [IDX_W-1:0] r;
        if (d == '0)
        begin
            r = '0;
        end
        else if (d > DIM_W'(MAX_DIM))
        begin
            r = IDX_W'(MAX_DIM - 1);
        end
        else
        begin
            r = IDX_W'(d - 1'b1);
        end
        return r;
    endfunction

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign stall     = res_valid_reg && !res.ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= DIM_W'(8);
            inner_dim_reg <= DIM_W'(8);
            cols_b_reg    <= DIM_W'(8);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROWS_A:    rows_a_reg    <= cfg_data;
                CFG_INNER_DIM: inner_dim_reg <= cfg_data;
                CFG_COLS_B:    cols_b_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Element loads.
    always_comb
    begin
        a_we  = 1'b0;
        b_we  = 1'b0;
        waddr = AW'(int'(cmd.row_index) * MAX_DIM + int'(cmd.col_index));
        if (cmd_fire && ({1'b0, cmd.row_index} < DIM_W'(MAX_DIM))
            && ({1'b0, cmd.col_index} < DIM_W'(MAX_DIM)))
        begin
            a_we = (cmd.kind == KIND_LOAD_A);
            b_we = (cmd.kind == KIND_LOAD_B);
        end
    end

    assign a_raddr = AW'(int'(i_reg) * MAX_DIM + int'(l_reg));
    assign b_raddr = AW'(int'(l_reg) * MAX_DIM + int'(j_reg));

    mme_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_a_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (waddr),
        .wdata (cmd.elem_value),
        .re    (!stall),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    mme_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (waddr),
        .wdata (cmd.elem_value),
        .re    (!stall),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // Sequencer: walks i, j and l and issues one pair of reads per cycle unless stalled.
    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        l_next      = l_reg;
        m_last_next = m_last_reg;
        k_last_next = k_last_reg;
        n_last_next = n_last_reg;
        issue       = 1'b0;
        s1_next     = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire && cmd.kind == KIND_START)
                begin
                    state_next  = ST_RUN;
                    i_next      = '0;
                    j_next      = '0;
                    l_next      = '0;
                    m_last_next = last_index(rows_a_reg);
                    k_last_next = last_index(inner_dim_reg);
                    n_last_next = last_index(cols_b_reg);
                end
            end
            ST_RUN:
            begin
                issue             = !stall;
                s1_next.valid     = 1'b1;
                s1_next.first     = (l_reg == '0);
                s1_next.last_term = (l_reg == k_last_reg);
                s1_next.last_elem = (i_reg == m_last_reg) && (j_reg == n_last_reg);
                s1_next.row       = i_reg;
                s1_next.col       = j_reg;
                if (issue)
                begin
                    if (l_reg != k_last_reg)
                    begin
                        l_next = l_reg + 1'b1;
                    end
                    else
                    begin
                        l_next = '0;
                        if (j_reg != n_last_reg)
                        begin
                            j_next = j_reg + 1'b1;
                        end
                        else
                        begin
                            j_next = '0;
                            if (i_reg != m_last_reg)
                            begin
                                i_next = i_reg + 1'b1;
                            end
                            else
                            begin
                                state_next = ST_DRAIN;
                            end
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!s1_reg.valid && !s2_reg.valid && !stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            l_reg      <= '0;
            m_last_reg <= '0;
            k_last_reg <= '0;
            n_last_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            l_reg      <= l_next;
            m_last_reg <= m_last_next;
            k_last_reg <= k_last_next;
            n_last_reg <= n_last_next;
        end
    end

    // MAC pipeline: read data, product, accumulate.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
        end
        else if (!stall)
        begin
            s1_reg <= issue ? s1_next : '0;
            s2_reg <= s1_reg;
        end
    end

    assign acc_next = s2_reg.first ? DOT_W'(prod_reg) : acc_reg + DOT_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            prod_reg <= $signed(a_rdata) * $signed(b_rdata);
            if (s2_reg.valid)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            res_valid_reg <= s2_reg.valid && s2_reg.last_term;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall && s2_reg.valid && s2_reg.last_term)
        begin
            res_row_reg  <= s2_reg.row;
            res_col_reg  <= s2_reg.col;
            res_dot_reg  <= acc_next;
            res_last_reg <= s2_reg.last_elem;
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.out_row   = res_row_reg;
    assign res.out_col   = res_col_reg;
    assign res.dot_value = res_dot_reg;
    assign res.last      = res_last_reg;
endmodule

@@ rtl/mme_checker.sv @@
// Port-level checks for the matrix multiply engine, bound to its top level.
// Depends on mme_pkg and the top level matrix_multiply_engine.
module mme_checker
    import mme_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    cmd_valid,
    input logic                    cmd_ready,
    input logic [KIND_W-1:0]       cmd_kind,
    input logic                    res_valid,
    input logic                    res_ready,
    input logic [IDX_W-1:0]        res_row,
    input logic [IDX_W-1:0]        res_col,
    input logic signed [DOT_W-1:0] res_dot,
    input logic                    res_last
);
    // A result that is waiting stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result item withdrawn before it was taken");

    // A waiting result keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_row) && $stable(res_col)
            && $stable(res_dot) && $stable(res_last))
        else $error("result item changed while stalled");

    // The engine only becomes busy on a start item.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(cmd_ready) |-> $past(cmd_valid && cmd_kind == KIND_START))
        else $error("engine went busy without a start item");

    // Once the final result of a run is taken the engine is idle again.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && res_last |=> cmd_ready)
        else $error("engine still busy after the final result item");
endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .cmd_kind  (cmd.kind),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_row   (res.out_row),
    .res_col   (res.out_col),
    .res_dot   (res.dot_value),
    .res_last  (res.last)
);
